// ===== hdl/oale_pkg.sv =====
// Shared types and constants for the ordered array list engine.
package oale_pkg;

   // Fixed field widths of the request and result channels
   localparam int POS_BITS    = 6;
   localparam int VALUE_BITS  = 32;
   localparam int LENGTH_BITS = 7;

   // Match encoder: cells are grouped in eights
   localparam int GROUP_SIZE = 8;
   localparam int GROUP_BITS = 3;

   // Request operation codes; codes 5 to 7 are rejected
   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_DELETE = 3'd1,
      OP_CHANGE = 3'd2,
      OP_SEARCH = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   // Command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_WRITE,
      CELL_COMPARE
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [POS_BITS-1:0] pos;
   } cell_cmd_type;

   // Control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_GROUP,
      ST_PICK
   } state_type;

endpackage

// ===== hdl/oale_cell.sv =====
// One list entry: holds a word, shifts with its neighbors, compares for search.
module oale_cell import oale_pkg::*; #(
   parameter int WORD_BITS  = 32,
   parameter int COUNT_BITS = 7,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  cell_cmd_type          cmd,
   input  logic [COUNT_BITS-1:0] count,
   input  logic [WORD_BITS-1:0]  word,
   input  logic [WORD_BITS-1:0]  left_data,
   input  logic [WORD_BITS-1:0]  right_data,
   output logic [WORD_BITS-1:0]  data,
   output logic                  match
);

   logic [WORD_BITS-1:0] data_ff;
   logic [WORD_BITS-1:0] data_in;
   logic                 match_ff;
   logic                 match_in;
   int                   pos_i;
   int                   count_i;

   assign pos_i   = int'(cmd.pos);
   assign count_i = int'(count);

   // Entry update: shift up on insert, down on delete, overwrite at the position
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (pos_i < INDEX) begin
               data_in = left_data;
            end else if (pos_i == INDEX) begin
               data_in = word;
            end
         end
         CELL_DELETE: begin
            if (pos_i <= INDEX) begin
               data_in = right_data;
            end
         end
         CELL_WRITE: begin
            if (pos_i == INDEX) begin
               data_in = word;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // Match only counts for entries inside the current length
   always_comb begin
      if (cmd.op == CELL_COMPARE) begin
         match_in = (data_ff == word) && (count_i > INDEX);
      end else begin
         match_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

// ===== hdl/oale_find.sv =====
// Two-level lowest-index encoder over the cells' match bits.
module oale_find import oale_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                clock,
   input  logic [CAPACITY-1:0] match,
   output logic                found,
   output logic [POS_BITS-1:0] index
);

   localparam int GROUPS    = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GSEL_BITS = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int FULL_BITS = GSEL_BITS + GROUP_BITS;

   logic [GROUPS*GROUP_SIZE-1:0] match_pad;
   logic [GROUPS-1:0]            group_any_in;
   logic [GROUPS-1:0]            group_any_ff;
   logic [GROUP_BITS-1:0]        group_idx_in [GROUPS];
   logic [GROUP_BITS-1:0]        group_idx_ff [GROUPS];
   logic [GSEL_BITS-1:0]         sel;
   logic [GROUP_BITS-1:0]        low;
   logic [FULL_BITS-1:0]         full_index;
   logic [FULL_BITS+POS_BITS-1:0] index_wide;

   assign match_pad = {{(GROUPS*GROUP_SIZE-CAPACITY){1'b0}}, match};

   // First level: lowest set bit inside each group of eight
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_any_in[g] = 1'b0;
         group_idx_in[g] = '0;
         for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
            if (match_pad[g*GROUP_SIZE + k]) begin
               group_any_in[g] = 1'b1;
               group_idx_in[g] = GROUP_BITS'(k);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_any_ff <= group_any_in;
      group_idx_ff <= group_idx_in;
   end

   // Second level: lowest group that holds a match
   always_comb begin
      found = 1'b0;
      sel   = '0;
      low   = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (group_any_ff[g]) begin
            found = 1'b1;
            sel   = GSEL_BITS'(g);
            low   = group_idx_ff[g];
         end
      end
   end

   assign full_index = {sel, low};
   assign index_wide = {{POS_BITS{1'b0}}, full_index};
   assign index      = index_wide[POS_BITS-1:0];

endmodule

// ===== hdl/ordered_array_list_engine_unit.sv =====
// Top level of the ordered array list engine: sequencer, length and cell chain.
//
//   channel   direction  handshake                   payload
//   request   in         start / busy                req_op, req_position, req_value
//   result    out        rsp_valid (one-cycle strobe) rsp_status, rsp_found,
//                                                     rsp_found_index, rsp_length,
//                                                     rsp_empty_flag, rsp_full_flag
//
// Insert, delete, change, clear and rejected codes: the whole chain of cells
// shifts or writes in the execute state.
// Search: the cells compare in the execute state, the first encoder level is
// registered in the group state, and the second level loads the result in the pick state.
// Reset clears the length and the sequencer; entry contents are not cleared.
// The result strobe is never held off; busy stays high until the result is out.
module ordered_array_list_engine_unit import oale_pkg::*; #(
   parameter int CAPACITY  = 64,
   parameter int WORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_op,
   input  logic [POS_BITS-1:0]          req_position,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   output logic                         rsp_status,
   output logic                         rsp_found,
   output logic [POS_BITS-1:0]          rsp_found_index,
   output logic [LENGTH_BITS-1:0]       rsp_length,
   output logic                         rsp_empty_flag,
   output logic                         rsp_full_flag
);

   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int CMP_BITS   = COUNT_BITS + POS_BITS;

   state_type               state_ff, state_in;
   op_type                  op_ff;
   logic [POS_BITS-1:0]     pos_ff;
   logic [WORD_BITS-1:0]    word_ff;
   logic [COUNT_BITS-1:0]   count_ff, count_in, count_next;
   logic                    accept;
   logic                    exec_status;
   logic                    exec_ok;
   logic signed [63:0]      value_ext;
   logic [CMP_BITS-1:0]     pos_ext;
   logic [CMP_BITS-1:0]     count_ext;
   logic                    list_full;
   cell_cmd_type            cell_cmd;
   logic [WORD_BITS-1:0]    cell_data [CAPACITY];
   logic [CAPACITY-1:0]     cell_match;
   logic                    find_found;
   logic [POS_BITS-1:0]     find_index;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POS_BITS-1:0]     rsp_index_ff, rsp_index_in;
   logic [LENGTH_BITS-1:0]  rsp_length_ff, rsp_length_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    rsp_full_ff, rsp_full_in;
   logic [COUNT_BITS+LENGTH_BITS-1:0] length_wide;

   assign accept    = start && (state_ff == ST_IDLE);
   assign value_ext = 64'(req_value);
   assign pos_ext   = {{COUNT_BITS{1'b0}}, pos_ff};
   assign count_ext = {{POS_BITS{1'b0}}, count_ff};
   assign list_full = (count_ff == COUNT_BITS'(CAPACITY));

   // Request checks against the current length
   always_comb begin
      exec_status = 1'b0;
      count_next  = count_ff;
      case (op_ff)
         OP_INSERT: begin
            if (list_full || (pos_ext > count_ext)) begin
               exec_status = 1'b1;
            end else begin
               count_next = count_ff + COUNT_BITS'(1);
            end
         end
         OP_DELETE: begin
            if (pos_ext >= count_ext) begin
               exec_status = 1'b1;
            end else begin
               count_next = count_ff - COUNT_BITS'(1);
            end
         end
         OP_CHANGE: begin
            exec_status = (pos_ext >= count_ext);
         end
         OP_SEARCH: begin
            exec_status = 1'b0;
         end
         OP_CLEAR: begin
            count_next = '0;
         end
         default: begin
            exec_status = 1'b1;
         end
      endcase
   end

   assign exec_ok = !exec_status;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = (op_ff == OP_SEARCH) ? ST_GROUP : ST_IDLE;
         end
         ST_GROUP: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: cell command, length update, result load
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      cell_cmd.op   = CELL_HOLD;
      cell_cmd.pos  = pos_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_index_in  = '0;
      case (state_ff)
         ST_EXEC: begin
            count_in = count_next;
            case (op_ff)
               OP_INSERT: cell_cmd.op = exec_ok ? CELL_INSERT : CELL_HOLD;
               OP_DELETE: cell_cmd.op = exec_ok ? CELL_DELETE : CELL_HOLD;
               OP_CHANGE: cell_cmd.op = exec_ok ? CELL_WRITE : CELL_HOLD;
               OP_SEARCH: cell_cmd.op = CELL_COMPARE;
               default:   cell_cmd.op = CELL_HOLD;
            endcase
            rsp_valid_in  = (op_ff != OP_SEARCH);
            rsp_status_in = exec_status;
         end
         ST_PICK: begin
            rsp_valid_in = 1'b1;
            rsp_found_in = find_found;
            rsp_index_in = find_found ? find_index : '0;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   assign length_wide   = {{LENGTH_BITS{1'b0}}, count_in};
   assign rsp_length_in = length_wide[LENGTH_BITS-1:0];
   assign rsp_empty_in  = (count_in == '0);
   assign rsp_full_in   = (count_in == COUNT_BITS'(CAPACITY));

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request capture on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_op);
         pos_ff  <= req_position;
         word_ff <= value_ext[WORD_BITS-1:0];
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_length_ff <= rsp_length_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_full_ff   <= rsp_full_in;
      end
   end

   // Chain of entry cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_data;
      logic [WORD_BITS-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = word_ff;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end
      oale_cell #(
         .WORD_BITS (WORD_BITS),
         .COUNT_BITS(COUNT_BITS),
         .INDEX     (i)
      ) u_cell (
         .clock     (clock),
         .cmd       (cell_cmd),
         .count     (count_ff),
         .word      (word_ff),
         .left_data (left_data),
         .right_data(right_data),
         .data      (cell_data[i]),
         .match     (cell_match[i])
      );
   end

   oale_find #(
      .CAPACITY(CAPACITY)
   ) u_find (
      .clock(clock),
      .match(cell_match),
      .found(find_found),
      .index(find_index)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_length      = rsp_length_ff;
   assign rsp_empty_flag  = rsp_empty_ff;
   assign rsp_full_flag   = rsp_full_ff;

endmodule

// ===== hdl/oale_checker.sv =====
// Port-level checks for the ordered array list engine, bound to the top level.
module oale_checker import oale_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic                   rsp_status,
   input logic                   rsp_found,
   input logic [POS_BITS-1:0]    rsp_found_index,
   input logic [LENGTH_BITS-1:0] rsp_length,
   input logic                   rsp_empty_flag,
   input logic                   rsp_full_flag
);

   // A transfer makes the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request transfer");

   // A new item must pass the execute state after each result, so results never come back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // Empty flag follows the reported length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_flag == (rsp_length == '0)))
      else $error("empty flag disagrees with length");

   // A list is never empty and full at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_empty_flag && rsp_full_flag))
      else $error("empty and full flags both set");

   // A miss reports index zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_found_index == '0))
      else $error("nonzero index without a match");

endmodule

bind ordered_array_list_engine_unit oale_checker u_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the ordered array list engine.
module testbench;
   import oale_pkg::*;

   localparam int LIST_DEPTH     = 64;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 160;

   // Codes outside the operation set; the block rejects them
   localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

   typedef struct {
      logic [2:0]                   op;
      logic [POS_BITS-1:0]          pos;
      logic signed [VALUE_BITS-1:0] value;
   } list_request_type;

   typedef struct {
      logic                   status;
      logic                   found;
      logic [POS_BITS-1:0]    found_index;
      logic [LENGTH_BITS-1:0] length;
      logic                   empty;
      logic                   full;
   } list_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [2:0]                   req_op = '0;
   logic [POS_BITS-1:0]          req_position = '0;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_status;
   logic                         rsp_found;
   logic [POS_BITS-1:0]          rsp_found_index;
   logic [LENGTH_BITS-1:0]       rsp_length;
   logic                         rsp_empty_flag;
   logic                         rsp_full_flag;

   list_request_type request_queue[$];
   list_result_type  pending_results[$];
   int            error_count = 0;
   int            sender_idle_pct = 0;
   int            idle_cycles = 0;

   // Shadow copy of the list contents and length
   logic [VALUE_BITS-1:0] list_words[LIST_DEPTH];
   int                    list_len = 0;

   // Stimulus planning: length seen by the generator, target length, value pool
   int                    plan_len = 0;
   int                    target_len = LIST_DEPTH;
   int                    hover_left = 0;
   logic [VALUE_BITS-1:0] value_pool[8];

   ordered_array_list_engine_unit #(
      .CAPACITY  (LIST_DEPTH),
      .WORD_BITS (VALUE_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .rsp_length      (rsp_length),
      .rsp_empty_flag  (rsp_empty_flag),
      .rsp_full_flag   (rsp_full_flag)
   );

   always #2 clock = ~clock;

   // Apply one operation to the shadow list and return the result it should give
   function automatic list_result_type apply_list_op(input logic [2:0] op,
                                                     input logic [POS_BITS-1:0] pos,
                                                     input logic [VALUE_BITS-1:0] word);
      list_result_type res;
      int              i;
      res = '{default: '0};
      case (op)
         OP_INSERT: begin
            if (list_len >= LIST_DEPTH || pos > list_len) begin
               res.status = 1'b1;
            end else begin
               for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
               list_words[pos] = word;
               list_len++;
            end
         end
         OP_DELETE: begin
            if (pos >= list_len) begin
               res.status = 1'b1;
            end else begin
               for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         OP_CHANGE: begin
            if (pos >= list_len) res.status = 1'b1;
            else list_words[pos] = word;
         end
         OP_SEARCH: begin
            // lowest matching index wins
            for (i = 0; i < list_len; i++) begin
               if (!res.found && list_words[i] == word) begin
                  res.found       = 1'b1;
                  res.found_index = i[POS_BITS-1:0];
               end
            end
         end
         OP_CLEAR: list_len = 0;
         default: res.status = 1'b1;
      endcase
      res.length = list_len[LENGTH_BITS-1:0];
      res.empty  = (list_len == 0);
      res.full   = (list_len == LIST_DEPTH);
      return res;
   endfunction

   // Length after an operation, as the generator sees it
   function automatic int length_after(input logic [2:0] op, input int pos, input int len);
      case (op)
         OP_INSERT: return (len < LIST_DEPTH && pos <= len) ? len + 1 : len;
         OP_DELETE: return (pos < len) ? len - 1 : len;
         OP_CLEAR:  return 0;
         default:   return len;
      endcase
   endfunction

   function automatic int pick_target();
      case ($urandom_range(2))
         0:       return LIST_DEPTH;
         1:       return 0;
         default: return $urandom_range(LIST_DEPTH);
      endcase
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      if ($urandom_range(99) < 70) return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   function automatic int valid_index(input int len);
      if (len == 0) return $urandom_range(LIST_DEPTH - 1);
      return $urandom_range(len - 1);
   endfunction

   task automatic queue_request(input logic [2:0] op, input int pos,
                                input logic [VALUE_BITS-1:0] value);
      list_request_type item;
      item.op    = op;
      item.pos   = pos[POS_BITS-1:0];
      item.value = value;
      request_queue.push_back(item);
      plan_len = length_after(op, pos, plan_len);
   endtask

   // Random item: walks the length toward a target, lingers there with mixed
   // operations, and mixes in some noise with random codes and positions
   task automatic queue_random_request();
      logic [2:0] op;
      int         r;
      r = $urandom_range(99);
      if (hover_left == 0 && plan_len == target_len) hover_left = $urandom_range(16, 4);
      if (r < 8) begin
         op = 3'($urandom_range(7));
         if (op == OP_CLEAR) op = OP_SEARCH;
         queue_request(op, $urandom_range(LIST_DEPTH - 1), $urandom);
      end else if (hover_left > 0) begin
         r = $urandom_range(99);
         if (r < 3)       queue_request(OP_CLEAR, $urandom_range(LIST_DEPTH - 1), $urandom);
         else if (r < 25) queue_request(OP_INSERT, $urandom_range(plan_len), pick_value());
         else if (r < 45) queue_request(OP_DELETE, valid_index(plan_len), $urandom);
         else if (r < 65) queue_request(OP_CHANGE, valid_index(plan_len), pick_value());
         else             queue_request(OP_SEARCH, $urandom_range(LIST_DEPTH - 1),
                                        pick_value());
         hover_left--;
         if (hover_left == 0) target_len = pick_target();
      end else if (plan_len < target_len) begin
         queue_request(OP_INSERT, $urandom_range(plan_len), pick_value());
      end else begin
         queue_request(OP_DELETE, valid_index(plan_len), $urandom);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Request driver: presents queued items, idling at random between transfers
   always @(posedge clock) begin : drive_requests
      logic             holding;
      list_request_type item;
      if (reset) begin
         start <= 1'b0;
      end else begin
         holding = start;
         if (start && !busy) begin
            pending_results.push_back(apply_list_op(req_op, req_position, req_value));
            holding = 1'b0;
         end
         if (!holding) begin
            if (request_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               item = request_queue.pop_front();
               start        <= 1'b1;
               req_op       <= item.op;
               req_position <= item.pos;
               req_value    <= item.value;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares every strobed result with the oldest expectation
   always @(posedge clock) begin : check_results
      list_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual length %0d",
                     $time, rsp_length);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("found", 32'(want.found), 32'(rsp_found));
            check_field("found_index", 32'(want.found_index), 32'(rsp_found_index));
            check_field("length", 32'(want.length), 32'(rsp_length));
            check_field("empty_flag", 32'(want.empty), 32'(rsp_empty_flag));
            check_field("full_flag", 32'(want.full), 32'(rsp_full_flag));
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_results.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : run_stimulus
      int phase_idle[4];
      int p;
      int n;
      // no sender idling; sender idle; no sender idling (receiver cannot stall); sender idle
      phase_idle = '{0, 52, 0, 34};
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'hffff_ffff;
      value_pool[3] = 32'h0000_0000;
      for (n = 4; n < 8; n++) value_pool[n] = $urandom;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list cases, extremes, every operation, rejected codes
      queue_request(OP_SEARCH, 0, 32'h0000_0000);
      queue_request(OP_DELETE, 0, 32'h0000_0000);
      queue_request(OP_CHANGE, 0, 32'h1234_5678);
      queue_request(OP_INSERT, 1, 32'h0000_0001);
      queue_request(OP_CLEAR, 0, 32'h0000_0000);
      queue_request(OP_INSERT, 0, 32'h8000_0000);
      queue_request(OP_INSERT, 1, 32'h7fff_ffff);
      queue_request(OP_INSERT, 0, 32'hffff_ffff);
      queue_request(OP_INSERT, 1, 32'h0000_0000);
      queue_request(OP_INSERT, 5, 32'h5555_aaaa);
      queue_request(OP_SEARCH, 63, 32'h7fff_ffff);
      queue_request(OP_SEARCH, 0, 32'h0001_2345);
      queue_request(OP_CHANGE, 3, 32'hffff_ffff);
      queue_request(OP_SEARCH, 0, 32'hffff_ffff);
      queue_request(OP_CHANGE, 4, 32'h0000_0002);
      queue_request(OP_DELETE, 0, 32'h0000_0000);
      queue_request(OP_DELETE, 2, 32'h0000_0000);
      queue_request(OP_DELETE, 3, 32'h0000_0000);
      for (n = OP_FIRST_UNUSED; n <= OP_LAST_UNUSED; n++)
         queue_request(n[2:0], 0, 32'h0000_0000);
      queue_request(OP_DELETE, 63, 32'hffff_ffff);
      queue_request(OP_CLEAR, 63, 32'hffff_ffff);
      queue_request(OP_SEARCH, 0, 32'h0000_0000);

      // Random phases with different idle rates
      for (p = 0; p < 4; p++) begin
         sender_idle_pct = phase_idle[p];
         for (n = 0; n < RANDOM_ITEMS; n++) queue_random_request();
         while (request_queue.size() != 0 || start) @(negedge clock);
      end

      // Drain outstanding results, then a few more cycles
      while (request_queue.size() != 0 || start || pending_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
